// ===== rtl/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types, constants and the reciprocal ROM for the RGB to HSV pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	// Hue scale and sector offsets
	localparam logic [15:0] HUE_SPAN      = 16'd43;
	localparam logic [7:0]  HUE_OFS_RED   = 8'd0;
	localparam logic [7:0]  HUE_OFS_GREEN = 8'd85;
	localparam logic [7:0]  HUE_OFS_BLUE  = 8'd171;

	// Reciprocal format: ceil(2^RECIP_FRAC / d), exact for 16-bit dividends
	localparam int RECIP_FRAC  = 24;
	localparam int RECIP_WIDTH = RECIP_FRAC + 1;
	localparam int NUM_WIDTH   = 16;
	localparam int PROD_WIDTH  = NUM_WIDTH + RECIP_WIDTH;

	typedef logic [RECIP_WIDTH-1:0] recip_t;
	typedef recip_t recip_rom_t [256];

	// Stage 1 result: extremes, hue difference and sector
	typedef struct packed {
		logic [7:0] mx;
		logic [7:0] span;
		logic [7:0] mag;
		logic       neg;
		logic [7:0] offset;
	} hue_term_t;

	// Build the ROM at elaboration by restoring long division; entry 0 is zero
	function automatic recip_rom_t build_recip();
		recip_rom_t rom;
		logic [RECIP_WIDTH:0] rem;
		logic [RECIP_WIDTH-1:0] quo;
		for (int d = 0; d < 256; d++) begin
			rem = '0;
			quo = '0;
			for (int i = RECIP_FRAC; i >= 0; i--) begin
				rem = {rem[RECIP_WIDTH-1:0], (i == RECIP_FRAC) ? 1'b1 : 1'b0};
				if (d != 0 && rem >= (RECIP_WIDTH+1)'(d)) begin
					rem = rem - (RECIP_WIDTH+1)'(d);
					quo[i] = 1'b1;
				end
			end
			if (d == 0)
				rom[d] = '0;
			else if (rem != '0)
				rom[d] = quo + recip_t'(1);
			else
				rom[d] = quo;
		end
		return rom;
	endfunction

	localparam recip_rom_t RECIP_ROM = build_recip();

endpackage

// ===== rtl/rgbhsv_sort.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_sort
// First pipeline stage: channel max/min, hue sector and signed difference.
// ----------------------------------------------------------------------------
module rgbhsv_sort (
	input  logic                  clk,
	input  logic                  en,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	output rgbhsv_pkg::hue_term_t term_s1
);
	import rgbhsv_pkg::*;

	hue_term_t term_c;
	logic [7:0] mn;

	// Find extremes; red wins ties over green, green over blue
	always_comb begin
		term_c.mx = red;
		mn = red;
		if (green > term_c.mx) term_c.mx = green;
		if (blue > term_c.mx)  term_c.mx = blue;
		if (green < mn)        mn = green;
		if (blue < mn)         mn = blue;
		term_c.span = term_c.mx - mn;
		if (term_c.mx == red) begin
			term_c.neg    = green < blue;
			term_c.mag    = term_c.neg ? blue - green : green - blue;
			term_c.offset = HUE_OFS_RED;
		end else if (term_c.mx == green) begin
			term_c.neg    = blue < red;
			term_c.mag    = term_c.neg ? red - blue : blue - red;
			term_c.offset = HUE_OFS_GREEN;
		end else begin
			term_c.neg    = red < green;
			term_c.mag    = term_c.neg ? green - red : red - green;
			term_c.offset = HUE_OFS_BLUE;
		end
	end

	// Hold the stage when downstream is blocked
	always_ff @(posedge clk) begin
		if (en) term_s1 <= term_c;
	end

endmodule

// ===== rtl/rgbhsv_rdiv.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_rdiv
// Two-stage rounded divider: round(num/den) via reciprocal ROM; den 0 gives 0.
// ----------------------------------------------------------------------------
module rgbhsv_rdiv (
	input  logic                              clk,
	input  logic                              en_a,
	input  logic                              en_b,
	input  logic [rgbhsv_pkg::NUM_WIDTH-1:0]  num,
	input  logic [7:0]                        den,
	output logic [7:0]                        quo_s3
);
	import rgbhsv_pkg::*;

	logic [NUM_WIDTH:0]      bias_sum;
	logic [NUM_WIDTH-1:0]    dividend_s2;
	recip_t                  recip_s2;
	logic [PROD_WIDTH-1:0]   prod;

	// Add half the divisor so the floor quotient rounds half up
	assign bias_sum = {1'b0, num} + (NUM_WIDTH+1)'(den[7:1]);

	always_ff @(posedge clk) begin
		if (en_a) begin
			dividend_s2 <= bias_sum[NUM_WIDTH-1:0];
			recip_s2    <= RECIP_ROM[den];
		end
	end

	// Multiply by the reciprocal and keep the integer part
	assign prod = PROD_WIDTH'(dividend_s2) * PROD_WIDTH'(recip_s2);

	always_ff @(posedge clk) begin
		if (en_b) quo_s3 <= prod[RECIP_FRAC +: 8];
	end

endmodule

// ===== rtl/rgb_to_hsv_8bit_pixel.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit_pixel
// Throughput: one pixel per cycle while the receiver does not stall; four register stages (sort, ROM lookup,
// reciprocal multiply, hue offset) each hold one pixel.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_8bit_pixel (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_valid,
	output logic       pixel_stall,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       hsv_valid,
	input  logic       hsv_stall,
	output logic [7:0] hue,
	output logic [7:0] saturation,
	output logic [7:0] brightness
);
	import rgbhsv_pkg::*;

	logic v1_s1, v2_s2, v3_s3;
	logic en1, en2, en3, en4;
	hue_term_t term_s1;
	logic [7:0] mx_s2, mx_s3;
	logic       neg_s2, neg_s3;
	logic [7:0] offset_s2, offset_s3;
	logic [NUM_WIDTH-1:0] hue_num, sat_num;
	logic [7:0] hue_q_s3, sat_q_s3;

	// Advance each stage when its slot is empty or the next one moves
	assign en4 = !hsv_valid || !hsv_stall;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign pixel_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			v3_s3     <= 1'b0;
			hsv_valid <= 1'b0;
		end else begin
			if (en1) v1_s1     <= pixel_valid;
			if (en2) v2_s2     <= v1_s1;
			if (en3) v3_s3     <= v2_s2;
			if (en4) hsv_valid <= v3_s3;
		end
	end

	rgbhsv_sort u_sort (
		.clk     (clk),
		.en      (en1),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.term_s1 (term_s1)
	);

	// Scale numerators: 43*diff for hue, 255*span for saturation
	assign hue_num = NUM_WIDTH'(term_s1.mag) * HUE_SPAN;
	assign sat_num = {term_s1.span, 8'd0} - NUM_WIDTH'(term_s1.span);

	rgbhsv_rdiv u_hue_div (
		.clk    (clk),
		.en_a   (en2),
		.en_b   (en3),
		.num    (hue_num),
		.den    (term_s1.span),
		.quo_s3 (hue_q_s3)
	);

	rgbhsv_rdiv u_sat_div (
		.clk    (clk),
		.en_a   (en2),
		.en_b   (en3),
		.num    (sat_num),
		.den    (term_s1.mx),
		.quo_s3 (sat_q_s3)
	);

	// Carry brightness and hue sector alongside the dividers
	always_ff @(posedge clk) begin
		if (en2) begin
			mx_s2     <= term_s1.mx;
			neg_s2    <= term_s1.neg;
			offset_s2 <= term_s1.offset;
		end
		if (en3) begin
			mx_s3     <= mx_s2;
			neg_s3    <= neg_s2;
			offset_s3 <= offset_s2;
		end
	end

	// Apply sector offset with modulo-256 wrap and drive the outputs
	always_ff @(posedge clk) begin
		if (en4) begin
			hue        <= neg_s3 ? offset_s3 - hue_q_s3 : offset_s3 + hue_q_s3;
			saturation <= sat_q_s3;
			brightness <= mx_s3;
		end
	end

endmodule

// ===== bench/tb_rgb_to_hsv_8bit_pixel.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_8bit_pixel
// Streams RGB pixels through the converter and compares every HSV result with
// a bit-exact predictor, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_8bit_pixel;
	import rgbhsv_pkg::*;

	localparam int          LATENCY     = 4;
	localparam int          HOLD_LEN    = 150;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int unsigned HUE_SCALE   = 32'(HUE_SPAN);
	localparam int unsigned SAT_SCALE   = 255;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} hsv_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_e;

	typedef enum logic [2:0] {
		PIX_ANY,
		PIX_GRAY,
		PIX_TIE,
		PIX_DIM,
		PIX_RAIL,
		PIX_NEAR_GRAY
	} pixel_kind_e;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       pixel_valid = 1'b0;
	logic       pixel_stall;
	logic [7:0] red         = 8'd0;
	logic [7:0] green       = 8'd0;
	logic [7:0] blue        = 8'd0;
	logic       hsv_valid;
	logic       hsv_stall   = 1'b0;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;

	hsv_t        hsv_expected[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	// receiver control: hold-off requests and end-of-run opening
	int unsigned hold_ask   = 0;
	int unsigned hold_seen  = 0;
	int unsigned hold_left  = 0;
	logic        rx_open_all = 1'b0;
	rx_mode_e    rx_mode    = RX_OPEN;
	int unsigned rx_left    = 0;
	int unsigned rx_phase   = 0;

	rgb_to_hsv_8bit_pixel dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.hsv_valid   (hsv_valid),
		.hsv_stall   (hsv_stall),
		.hue         (hue),
		.saturation  (saturation),
		.brightness  (brightness)
	);

	always #1 clk = ~clk;

	// Compute full-range HSV with exact rounded quotients
	function automatic hsv_t predict_hsv(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int unsigned ri, gi, bi, mx, mn, span, mag, q, sat;
		logic        neg;
		logic [7:0]  ofs;
		hsv_t        res;
		ri = 32'(r);
		gi = 32'(g);
		bi = 32'(b);
		mx = ri;
		if (gi > mx) mx = gi;
		if (bi > mx) mx = bi;
		mn = ri;
		if (gi < mn) mn = gi;
		if (bi < mn) mn = bi;
		span = mx - mn;
		// red wins ties, then green
		if (mx == ri) begin
			neg = gi < bi;
			mag = neg ? bi - gi : gi - bi;
			ofs = HUE_OFS_RED;
		end else if (mx == gi) begin
			neg = bi < ri;
			mag = neg ? ri - bi : bi - ri;
			ofs = HUE_OFS_GREEN;
		end else begin
			neg = ri < gi;
			mag = neg ? gi - ri : ri - gi;
			ofs = HUE_OFS_BLUE;
		end
		q = (span != 0) ? (2 * HUE_SCALE * mag + span) / (2 * span) : 0;
		sat = (mx != 0) ? (2 * SAT_SCALE * span + mx) / (2 * mx) : 0;
		res.hue        = neg ? ofs - q[7:0] : ofs + q[7:0];
		res.saturation = sat[7:0];
		res.brightness = mx[7:0];
		return res;
	endfunction

	// Offer one pixel and hold it until accepted
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		pixel_valid <= 1'b1;
		red         <= r;
		green       <= g;
		blue        <= b;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		hsv_expected.push_back(predict_hsv(r, g, b));
	endtask

	// Drop valid and idle the sender for a number of cycles
	task automatic pause_sender(input int unsigned cycles);
		if (cycles != 0) begin
			pixel_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Idle the sender until every pending result has been taken
	task automatic wait_for_results();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (hsv_expected.size() != 0) @(posedge clk);
	endtask

	// Pick a pixel from one of several shapes that stress the sorting and rounding
	task automatic random_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
		pixel_kind_e kind;
		logic [7:0]  top, other, low;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)      kind = PIX_ANY;
		else if (pick < 55) kind = PIX_GRAY;
		else if (pick < 72) kind = PIX_TIE;
		else if (pick < 82) kind = PIX_DIM;
		else if (pick < 90) kind = PIX_RAIL;
		else                kind = PIX_NEAR_GRAY;
		r = 8'($urandom);
		g = 8'($urandom);
		b = 8'($urandom);
		case (kind)
			PIX_GRAY: begin
				g = r;
				b = r;
			end
			PIX_TIE: begin
				top   = 8'($urandom);
				other = 8'($urandom_range(0, 32'(top)));
				case ($urandom_range(0, 2))
					0: begin r = top; g = top; b = other; end
					1: begin r = other; g = top; b = top; end
					default: begin r = top; g = other; b = top; end
				endcase
			end
			PIX_DIM: begin
				r = 8'($urandom_range(0, 3));
				g = 8'($urandom_range(0, 3));
				b = 8'($urandom_range(0, 3));
			end
			PIX_RAIL: begin
				r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				b = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
			end
			PIX_NEAR_GRAY: begin
				low = 8'($urandom_range(0, 250));
				r = low + 8'($urandom_range(0, 5));
				g = low + 8'($urandom_range(0, 5));
				b = low + 8'($urandom_range(0, 5));
			end
			default: ;
		endcase
	endtask

	// Send a burst of random pixels with no gap inside it
	task automatic send_random_burst(input int unsigned count);
		logic [7:0] r, g, b;
		repeat (count) begin
			random_pixel(r, g, b);
			send_pixel(r, g, b);
		end
	endtask

	// Extremes, ties, gray, black, wrapped hue and half-way rounding
	task automatic test_directed();
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd1,   8'd1,   8'd1);
		send_pixel(8'd1,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd0,   8'd10);
		send_pixel(8'd10,  8'd255, 8'd0);
		send_pixel(8'd0,   8'd10,  8'd255);
		send_pixel(8'd2,   8'd1,   8'd0);
		send_pixel(8'd2,   8'd0,   8'd1);
		send_pixel(8'd0,   8'd2,   8'd1);
		send_pixel(8'd1,   8'd0,   8'd2);
		send_pixel(8'd255, 8'd254, 8'd0);
		send_pixel(8'd170, 8'd85,  8'd85);
		send_pixel(8'hAA,  8'h55,  8'hFF);
		send_pixel(8'h55,  8'hAA,  8'h00);
		wait_for_results();
	endtask

	// Random bursts with random gaps, some stretches back to back
	task automatic test_random_stream(input int unsigned count);
		int unsigned sent, len;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(1, 16);
			if (len > count - sent) len = count - sent;
			send_random_burst(len);
			sent += len;
			if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
		end
	endtask

	// Hold the receiver off while the sender keeps offering, so the pipe fills
	task automatic test_backpressure();
		hold_ask <= hold_ask + 1;
		send_random_burst(60);
		wait_for_results();
	endtask

	// Let the pipe drain completely between bursts
	task automatic test_drain_between_bursts();
		repeat (7) begin
			send_random_burst($urandom_range(1, 20));
			wait_for_results();
		end
	endtask

	// Take results, check them, and stall on a pattern independent of the sender
	always @(posedge clk) begin
		hsv_t got, want;
		if (arst_n && hsv_valid && !hsv_stall) begin
			got = '{hue: hue, saturation: saturation, brightness: brightness};
			if (hsv_expected.size() == 0) begin
				$display("%0t: unexpected result hue=%0d saturation=%0d brightness=%0d",
					$time, got.hue, got.saturation, got.brightness);
				error_count++;
			end else begin
				want = hsv_expected.pop_front();
				if (got.hue != want.hue) begin
					$display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
					error_count++;
				end
				if (got.saturation != want.saturation) begin
					$display("%0t: saturation expected %0d actual %0d",
						$time, want.saturation, got.saturation);
					error_count++;
				end
				if (got.brightness != want.brightness) begin
					$display("%0t: brightness expected %0d actual %0d",
						$time, want.brightness, got.brightness);
					error_count++;
				end
			end
		end

		// switch stall pattern now and then
		if (rx_left == 0) begin
			rx_mode  <= rx_mode_e'($urandom_range(0, 3));
			rx_left  <= $urandom_range(20, 200);
			rx_phase <= 0;
		end else begin
			rx_left  <= rx_left - 1;
			rx_phase <= rx_phase + 1;
		end

		if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			hold_left <= HOLD_LEN;
			hsv_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			hsv_stall <= 1'b1;
		end else if (rx_open_all) begin
			hsv_stall <= 1'b0;
		end else begin
			case (rx_mode)
				RX_LIGHT:    hsv_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY:    hsv_stall <= ($urandom_range(0, 3) != 0);
				RX_PERIODIC: hsv_stall <= (rx_phase % 5) < 2;
				default:     hsv_stall <= 1'b0;
			endcase
		end
	end

	// End the run if it takes far longer than any correct run could
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("rgb_to_hsv_8bit_pixel: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_stream(600);
		test_backpressure();
		test_drain_between_bursts();
		test_random_stream(500);

		// drain, open the receiver and watch for stray results
		wait_for_results();
		rx_open_all <= 1'b1;
		repeat (LATENCY + 20) @(posedge clk);
		if (error_count == 0)
			$display("rgb_to_hsv_8bit_pixel: match");
		else
			$display("rgb_to_hsv_8bit_pixel: mismatch");
		$finish;
	end

endmodule
